// File: src/deq_pkg.sv
// Shared constants and types for the double-ended queue.
// Depends on nothing; every other file of the block imports it.
package deq_pkg;

  localparam int DEPTH   = 256;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int WORD_W  = 64;
  localparam int MODE_W  = 3;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_READ_INDEX = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted word's fields
    logic exec;   // perform the operation on the store and pointers
  } deq_cmd_t;

endpackage

// File: src/deq_in_if.sv
// Input channel of the double-ended queue: valid/ready plus one operation word.
// Depends on deq_pkg.
interface deq_in_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [WORD_W-1:0]   value;
  logic [POS_W-1:0]    position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

// File: src/deq_out_if.sv
// Result channel of the double-ended queue: valid/ready plus one result word.
// Depends on deq_pkg.
interface deq_out_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   data_out;
  logic [CNT_W-1:0]    count;
  logic                is_empty;
  logic [STAT_W-1:0]   status;

  modport source (output valid, data_out, count, is_empty, status, input ready);
  modport sink   (input valid, data_out, count, is_empty, status, output ready);
endinterface

// File: src/deq_ctrl.sv
// Controller of the double-ended queue: sequences accept, execute and respond.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::deq_cmd_t cmd
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/deq_dpath.sv
// Datapath of the double-ended queue: word store, head pointer, element count
// and the result register. Depends on deq_pkg.
module deq_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  deq_pkg::deq_cmd_t           cmd,
  input  logic [deq_pkg::MODE_W-1:0]  in_mode,
  input  logic [deq_pkg::WORD_W-1:0]  in_value,
  input  logic [deq_pkg::POS_W-1:0]   in_position,
  output logic [deq_pkg::WORD_W-1:0]  out_data_out,
  output logic [deq_pkg::CNT_W-1:0]   out_count,
  output logic                        out_is_empty,
  output logic [deq_pkg::STAT_W-1:0]  out_status
);
  import deq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [MODE_W-1:0] op_mode_r;
  logic [WORD_W-1:0] op_value_r;
  logic [POS_W-1:0]  op_pos_r;

  logic [PTR_W-1:0]  head_r,   head_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [WORD_W-1:0] rd_q_r;
  logic              rd_hit_r;

  logic              wr_en;
  logic              rd_en;
  logic [PTR_W-1:0]  addr;
  logic              full;
  logic              empty;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    addr       = head_r;
    case (op_mode_r)
      MODE_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          addr      = head_r + count_r[PTR_W-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          head_nxt  = head_r - 1'b1;
          addr      = head_r - 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          addr  = head_r;
          if (op_mode_r == MODE_POP_FRONT) begin
            head_nxt  = head_r + 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          addr  = head_r + count_r[PTR_W-1:0] - 1'b1;
          if (op_mode_r == MODE_POP_BACK) count_nxt = count_r - 1'b1;
        end
      end
      MODE_READ_INDEX: begin
        if (CNT_W'(op_pos_r) >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_en = 1'b1;
          addr  = head_r + PTR_W'(op_pos_r);
        end
      end
      MODE_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Operation fields are captured at accept time.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode_r  <= in_mode;
      op_value_r <= in_value;
      op_pos_r   <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[addr] <= op_value_r;
    if (cmd.exec && rd_en) rd_q_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      status_r <= ST_OK;
      rd_hit_r <= 1'b0;
    end else if (cmd.exec) begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      rd_hit_r <= rd_en;
    end
  end

  assign out_data_out = rd_hit_r ? rd_q_r : '0;
  assign out_count    = count_r;
  assign out_is_empty = (count_r == '0);
  assign out_status   = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count exceeds the store depth");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_mode_r == MODE_CLEAR |=> count_r == '0 && head_r == '0)
    else $error("clear did not reset count and head");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && wr_en |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted push did not grow the count");

  a_err_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && status_nxt != ST_OK |-> !rd_en && !wr_en)
    else $error("failing operation touched the store");

endmodule

// File: src/double_ended_queue_core.sv
// Top level of the double-ended queue of 64-bit words.
// Depends on deq_pkg, deq_in_if, deq_out_if, deq_ctrl and deq_dpath.
// Usage:
//   in_ch carries one operation word per handshake: mode, value, position.
//   out_ch returns exactly one result word per accepted operation: the popped,
//   peeked or indexed word (zero otherwise), the count afterwards, an empty
//   flag and a status (ok, empty error, index out of range, full refused).
//   Words are accepted when valid and ready are both high at a rising edge.
// Sequencing:
//   An operation is accepted, executed against the 256-entry store in the
//   next cycle (one store access, registered read), and presented as a result
//   the cycle after. One operation is in flight at a time, so the block takes
//   no new word until the result of the last one has been taken. The store's
//   single registered port and the three-state controller impose this order.
// Reset:
//   Synchronous, active low rst_n empties the queue (head and count zero)
//   and drops out_ch.valid. The store contents are not cleared.
// Stall:
//   While out_ch.ready is low, the result holds steady and in_ch.ready stays
//   low; no operation is lost.
module double_ended_queue_core (
  input  logic    clk,
  input  logic    rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  deq_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_mode      (in_ch.mode),
    .in_value     (in_ch.value),
    .in_position  (in_ch.position),
    .out_data_out (out_ch.data_out),
    .out_count    (out_ch.count),
    .out_is_empty (out_ch.is_empty),
    .out_status   (out_ch.status)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue_core: drives operation words,
// predicts each result with a shadow copy of the queue and compares field by field.
// Depends on deq_pkg, deq_in_if, deq_out_if and the block itself.
module testbench;
  import deq_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic [STAT_W-1:0] status;
  } deq_result_t;

  logic clk;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Shadow copy of the queue; only live slots are ever read.
  logic [WORD_W-1:0] shadow_words [DEPTH];
  logic [PTR_W-1:0]  shadow_head;
  logic [CNT_W-1:0]  shadow_count;

  deq_result_t pending_results [$];
  int          error_count;
  bit          steady;  // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic deq_result_t deque_step(input logic [MODE_W-1:0] mode,
                                              input logic [WORD_W-1:0] value,
                                              input logic [POS_W-1:0]  position);
    deq_result_t      r;
    logic [PTR_W-1:0] back;
    r.data   = '0;
    r.status = ST_OK;
    back = shadow_head + shadow_count[PTR_W-1:0] - 1'b1;
    case (mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (shadow_count == CNT_W'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          if (mode == MODE_PUSH_BACK) begin
            shadow_words[shadow_head + shadow_count[PTR_W-1:0]] = value;
          end else begin
            shadow_head = shadow_head - 1'b1;
            shadow_words[shadow_head] = value;
          end
          shadow_count = shadow_count + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT) begin
            r.data = shadow_words[shadow_head];
          end else begin
            r.data = shadow_words[back];
          end
          if (mode == MODE_POP_FRONT) shadow_head = shadow_head + 1'b1;
          if (mode == MODE_POP_FRONT || mode == MODE_POP_BACK) begin
            shadow_count = shadow_count - 1'b1;
          end
        end
      end
      MODE_READ_INDEX: begin
        if (CNT_W'(position) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.data = shadow_words[shadow_head + PTR_W'(position)];
        end
      end
      default: begin
        shadow_head  = '0;
        shadow_count = '0;
      end
    endcase
    r.count    = shadow_count;
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  // Sends one word; valid stays high on return so back-to-back words need no gap.
  task automatic issue_op(input logic [MODE_W-1:0] mode,
                          input logic [WORD_W-1:0] value = '0,
                          input logic [POS_W-1:0]  position = '0);
    int          gap;
    deq_result_t predicted;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 25) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.value    <= value;
    in_ch.position <= position;
    do @(posedge clk); while (!in_ch.ready);
    predicted = deque_step(mode, value, position);
    pending_results = {pending_results, predicted};
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Result side: random backpressure and a compare against the oldest prediction.
  initial begin
    deq_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word arrived with no operation outstanding");
          error_count++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_ch.data_out !== want.data) begin
            $error("data_out: expected %h, got %h", want.data, out_ch.data_out);
            error_count++;
          end
          if (out_ch.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_ch.count);
            error_count++;
          end
          if (out_ch.is_empty !== want.is_empty) begin
            $error("is_empty: expected %b, got %b", want.is_empty, out_ch.is_empty);
            error_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            error_count++;
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic test_empty_errors();
    issue_op(MODE_POP_FRONT);
    issue_op(MODE_POP_BACK);
    issue_op(MODE_PEEK_FRONT);
    issue_op(MODE_PEEK_BACK);
    issue_op(MODE_READ_INDEX, '0, 8'd0);
    issue_op(MODE_READ_INDEX, '0, 8'hFF);
    issue_op(MODE_CLEAR, '1, 8'hFF);
  endtask

  task automatic test_basic_ops();
    issue_op(MODE_PUSH_BACK, '1);
    issue_op(MODE_PUSH_FRONT, '0);
    issue_op(MODE_PUSH_BACK, {32{2'b01}});
    issue_op(MODE_PUSH_FRONT, {32{2'b10}});
    issue_op(MODE_PEEK_FRONT);
    issue_op(MODE_PEEK_BACK);
    for (int i = 0; i <= 4; i++) issue_op(MODE_READ_INDEX, '0, POS_W'(i));
    issue_op(MODE_POP_FRONT);
    issue_op(MODE_POP_BACK);
    issue_op(MODE_CLEAR);
  endtask

  // Fills the store from both ends so the head wraps, then probes the full case.
  task automatic test_full_store();
    while (shadow_count < CNT_W'(DEPTH)) begin
      issue_op($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, random_word());
    end
    issue_op(MODE_PUSH_BACK, random_word());
    issue_op(MODE_PUSH_FRONT, random_word());
    issue_op(MODE_READ_INDEX, '0, 8'hFF);
    issue_op(MODE_READ_INDEX, '0, 8'h80);
    issue_op(MODE_PEEK_FRONT);
    issue_op(MODE_PEEK_BACK);
    issue_op(MODE_POP_FRONT);
    issue_op(MODE_POP_BACK);
    issue_op(MODE_PUSH_FRONT, random_word());
    issue_op(MODE_PUSH_BACK, random_word());
    issue_op(MODE_CLEAR);
  endtask

  // Random walk of the fill level toward a target that moves now and then.
  task automatic test_random_mix(input int n_ops);
    int               target;
    int               roll;
    logic             grow;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    target = 16;
    for (int i = 0; i < n_ops; i++) begin
      steady = (i >= n_ops / 3) && (i < n_ops / 3 + 100);
      if (i % 40 == 0) begin
        target = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(0, 64);
      end
      roll = $urandom_range(0, 99);
      grow = (int'(shadow_count) < target);
      if (roll < 60) grow = (roll < 47) ? grow : !grow;
      if (roll < 2) begin
        mode = MODE_CLEAR;
      end else if (roll < 60) begin
        if (grow) mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        else      mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      end else if (roll < 70) begin
        mode = MODE_PEEK_FRONT;
      end else if (roll < 80) begin
        mode = MODE_PEEK_BACK;
      end else begin
        mode = MODE_READ_INDEX;
      end
      if (shadow_count != 0 && $urandom_range(0, 99) < 80) begin
        position = POS_W'($urandom_range(0, int'(shadow_count) - 1));
      end else begin
        position = POS_W'($urandom_range(0, 255));
      end
      issue_op(mode, random_word(), position);
    end
    steady = 1'b0;
  endtask

  initial begin
    error_count     = 0;
    steady          = 1'b0;
    shadow_head     = '0;
    shadow_count    = '0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_PUSH_BACK;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_errors();
    test_basic_ops();
    wait_drained();
    test_full_store();
    wait_drained();
    test_random_mix(350);
    wait_drained();
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
